// ----- rtl/twpa_pkg.sv -----
// Package: shared types and constants of the pose averager.
`default_nettype none
package twpa_pkg;
  localparam int unsigned HistDepth = 64;
  localparam int unsigned IdxW = $clog2(HistDepth);
  localparam int unsigned CntW = $clog2(HistDepth + 1);
  localparam int unsigned SumW = 32 + CntW;
  localparam logic [31:0] WindowReset = 32'd100000;
  localparam int unsigned PAddrW = 2;
  localparam logic [PAddrW-1:0] RegWindow = 2'd0;

  typedef enum logic [2:0] {
    StIdle, StStore, StRead, StScan, StDiv, StOut
  } state_e;

  typedef struct packed {
    logic [31:0] t;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [63:0] q;
  } entry_t;
endpackage
`default_nettype wire

// ----- rtl/twpa_if.sv -----
// Interfaces: valid/ready channels for input poses and averaged results.
`default_nettype none
interface twpa_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_time;
  logic        moving;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [15:0] quat_x;
  logic [15:0] quat_y;
  logic [15:0] quat_z;
  logic [15:0] quat_w;
  modport source (output valid, sample_time, moving, pos_x, pos_y, pos_z,
                  quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink (input valid, sample_time, moving, pos_x, pos_y, pos_z,
                quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface twpa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] avg_pos_x;
  logic [31:0] avg_pos_y;
  logic [31:0] avg_pos_z;
  logic [15:0] avg_quat_x;
  logic [15:0] avg_quat_y;
  logic [15:0] avg_quat_z;
  logic [15:0] avg_quat_w;
  logic [6:0]  samples_used;
  modport source (output valid, avg_pos_x, avg_pos_y, avg_pos_z, avg_quat_x,
                  avg_quat_y, avg_quat_z, avg_quat_w, samples_used, input ready);
  modport sink (input valid, avg_pos_x, avg_pos_y, avg_pos_z, avg_quat_x,
                avg_quat_y, avg_quat_z, avg_quat_w, samples_used, output ready);
endinterface
`default_nettype wire

// ----- rtl/twpa_div.sv -----
// Divider: restoring signed division of seven sums by one count, one bit a cycle.
`default_nettype none
module twpa_div
  import twpa_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [6:0][SumW-1:0]       sum_i,
  input  wire logic [CntW-1:0]            cnt_i,
  output logic                            done_o,
  output logic [6:0][31:0]                quo_o
);
  localparam int unsigned StepW = $clog2(SumW + 1);

  logic [6:0][SumW-1:0] num_q, num_d;
  logic [6:0][CntW:0]   rem_q, rem_d;
  logic [6:0]           neg_q, neg_d;
  logic [StepW-1:0]     step_q, step_d;
  logic                 busy_q, busy_d;
  logic [CntW-1:0]      den_q, den_d;

  always_comb begin
    logic [CntW:0] trial;
    trial  = '0;
    num_d  = num_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    step_d = step_q;
    busy_d = busy_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = StepW'(SumW);
      den_d  = cnt_i;
      for (int i = 0; i < 7; i++) begin
        neg_d[i] = sum_i[i][SumW-1];
        num_d[i] = sum_i[i][SumW-1] ? (~sum_i[i] + 1'b1) : sum_i[i];
        rem_d[i] = '0;
      end
    end else if (busy_q) begin
      for (int i = 0; i < 7; i++) begin
        trial = {rem_q[i][CntW-1:0], num_q[i][SumW-1]};
        num_d[i] = {num_q[i][SumW-2:0], 1'b0};
        if (trial >= {1'b0, den_q}) begin
          rem_d[i] = trial - {1'b0, den_q};
          num_d[i][0] = 1'b1;
        end else begin
          rem_d[i] = trial;
        end
      end
      step_d = step_q - 1'b1;
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
      end
    end
    done_o = busy_q && (step_q == StepW'(1));
  end

  always_comb begin
    for (int i = 0; i < 7; i++) begin
      quo_o[i] = neg_q[i] ? 32'(~num_d[i] + 1'b1) : num_d[i][31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    den_q <= den_d;
  end
endmodule
`default_nettype wire

// ----- rtl/time_window_pose_averager_core.sv -----
// Top level: time-windowed pose averager with history memory and sequencer.
// Each beat runs these steps from accept to the next accept when the result
// is taken at once: the accept, a store of the new pose, a read state and a
// scan state for each held sample while the sequencer walks them through a
// single memory read port, compacting fresh ones and accumulating seven sums,
// then a shared restoring divider run, and the result handshake. Moving
// beats skip the history and the divider, go straight to the output register
// and clear the history. The block is not ready while busy; the result waits
// in an output register until taken.
`default_nettype none
module time_window_pose_averager_core
  import twpa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PAddrW-1:0]  paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  twpa_in_if.sink                 in_if,
  twpa_out_if.source              out_if
);
  // memory: one write port, one registered read port
  entry_t          mem [HistDepth];
  logic            wr_en;
  logic [IdxW-1:0] wr_addr, rd_addr;
  entry_t          wr_data, rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  logic [31:0] window_q;
  assign pready = 1'b1;
  assign prdata = (paddr == RegWindow) ? window_q : '0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowReset;
    end else if (psel && penable && pwrite && paddr == RegWindow) begin
      window_q <= pwdata;
    end
  end

  state_e state_q, state_d;
  logic [IdxW-1:0] oldest_q, oldest_d;
  logic [CntW-1:0] held_q, held_d, k_q, k_d, kept_q, kept_d;
  logic [31:0]     now_q;
  entry_t          new_q;
  logic [6:0][SumW-1:0] sum_q, sum_d;
  logic [6:0][31:0] res_q, res_d, quo;
  logic [6:0]      used_q, used_d;
  logic            ov_q, ov_d;
  logic            div_start, div_done;

  wire in_fire = in_if.valid && in_if.ready;
  assign in_if.ready  = (state_q == StIdle) && !ov_q;
  assign out_if.valid = ov_q;
  assign out_if.avg_pos_x = res_q[0];
  assign out_if.avg_pos_y = res_q[1];
  assign out_if.avg_pos_z = res_q[2];
  assign out_if.avg_quat_x = res_q[3][15:0];
  assign out_if.avg_quat_y = res_q[4][15:0];
  assign out_if.avg_quat_z = res_q[5][15:0];
  assign out_if.avg_quat_w = res_q[6][15:0];
  assign out_if.samples_used = used_q;

  // sums and kept count for the divider include the last sample's fresh bit
  twpa_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .sum_i(sum_d), .cnt_i(kept_d),
    .done_o(div_done), .quo_o(quo)
  );

  // fresh test: t + window >= now, exact in 33 bits
  wire fresh = ({1'b0, rd_data_q.t} + {1'b0, window_q}) >= {1'b0, now_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_fire) state_d = in_if.moving ? StIdle : StStore;
      StStore: state_d = StRead;
      StRead:  state_d = StScan;
      StScan:  if (k_q == held_q - 1'b1) state_d = StDiv;
               else state_d = StRead;
      StDiv:   if (div_done) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    oldest_d = oldest_q;
    held_d   = held_q;
    k_d      = k_q;
    kept_d   = kept_q;
    sum_d    = sum_q;
    res_d    = res_q;
    used_d   = used_q;
    ov_d     = ov_q && !out_if.ready;
    wr_en    = 1'b0;
    wr_addr  = IdxW'(oldest_q + IdxW'(held_q));
    wr_data  = new_q;
    rd_addr  = IdxW'(oldest_q + IdxW'(k_q));
    div_start = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_fire && in_if.moving) begin
          held_d = '0;
          oldest_d = '0;
          res_d = {{16'd0, in_if.quat_w}, {16'd0, in_if.quat_z},
                   {16'd0, in_if.quat_y}, {16'd0, in_if.quat_x},
                   in_if.pos_z, in_if.pos_y, in_if.pos_x};
          used_d = '0;
          ov_d = 1'b1;
        end
      end
      StStore: begin
        // full history: drop the oldest first
        if (held_q == CntW'(HistDepth)) begin
          oldest_d = oldest_q + 1'b1;
          wr_addr  = oldest_q;
        end else begin
          held_d = held_q + 1'b1;
        end
        wr_en  = 1'b1;
        k_d    = '0;
        kept_d = '0;
        sum_d  = '0;
      end
      StScan: begin
        if (fresh) begin
          wr_en   = 1'b1;
          wr_addr = IdxW'(oldest_q + IdxW'(kept_q));
          wr_data = rd_data_q;
          kept_d  = kept_q + 1'b1;
          sum_d[0] = sum_q[0] + SumW'($signed(rd_data_q.px));
          sum_d[1] = sum_q[1] + SumW'($signed(rd_data_q.py));
          sum_d[2] = sum_q[2] + SumW'($signed(rd_data_q.pz));
          for (int i = 0; i < 4; i++) begin
            sum_d[3+i] = sum_q[3+i] + SumW'($signed(rd_data_q.q[16*i +: 16]));
          end
        end
        k_d = k_q + 1'b1;
        if (k_q == held_q - 1'b1) begin
          held_d = fresh ? kept_q + 1'b1 : kept_q;
          div_start = 1'b1;
        end
      end
      StDiv: begin
        kept_d = held_q;
        if (div_done) begin
          res_d  = quo;
          used_d = 7'(held_q);
          ov_d   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      oldest_q <= '0;
      held_q   <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      oldest_q <= oldest_d;
      held_q   <= held_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    kept_q <= kept_d;
    sum_q  <= sum_d;
    res_q  <= res_d;
    used_q <= used_d;
    if (in_fire) begin
      now_q <= in_if.sample_time;
      new_q <= '{t: in_if.sample_time, px: in_if.pos_x, py: in_if.pos_y,
                 pz: in_if.pos_z,
                 q: {in_if.quat_w, in_if.quat_z, in_if.quat_y, in_if.quat_x}};
    end
  end
endmodule
`default_nettype wire
